/* hdl/rlsd_pkg.sv */
// ----------------------------------------------------------------------------
// rlsd_pkg
// Command codes, status codes and shared types for the ring list block.
// ----------------------------------------------------------------------------
package rlsd_pkg;

  localparam logic [2:0] MODE_INS_FRONT = 3'd0;
  localparam logic [2:0] MODE_INS_BACK  = 3'd1;
  localparam logic [2:0] MODE_DEL_FRONT = 3'd2;
  localparam logic [2:0] MODE_DEL_BACK  = 3'd3;
  localparam logic [2:0] MODE_SORT      = 3'd4;
  localparam logic [2:0] MODE_DEDUP     = 3'd5;
  localparam logic [2:0] MODE_READ      = 3'd6;
  localparam logic [2:0] MODE_NONE      = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic signed [31:0] word_t;

endpackage

/* hdl/ring_list_sort_dedup_top.sv */
// ----------------------------------------------------------------------------
// ring_list_sort_dedup_top
// Bounded circular list: end insert/delete, exchange sort, dedup, read-out.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid, in_stall, mode, value          | into block
//  out     | out_valid, out_stall, status, entry_value, | out of block
//          | entry_count, last                        |
//
//  Insert/delete/empty/bad mode: a single result per command.
//  Read-out: one entry at a time, paced by the one RAM read port.
//  Sort: n(n-1)/2 compared pairs; an exchange adds a write state (S_SO_W).
//  Dedup: a single pass. rst clears state, out_valid, front index and count.
//  A stalled result holds; no new command is taken until all results go.
// ----------------------------------------------------------------------------
module ring_list_sort_dedup_top #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic signed [31:0] entry_value,
  output logic [5:0]  entry_count,
  output logic        last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [5:0] DEPTH_C = 6'(DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_OUT   = 4'd1;
  localparam logic [3:0] S_RD_A  = 4'd2;
  localparam logic [3:0] S_RD_W  = 4'd3;
  localparam logic [3:0] S_RD_O  = 4'd4;
  localparam logic [3:0] S_SO_A  = 4'd5;
  localparam logic [3:0] S_SO_B  = 4'd6;
  localparam logic [3:0] S_SO_C  = 4'd7;
  localparam logic [3:0] S_SO_W  = 4'd8;
  localparam logic [3:0] S_DD_W  = 4'd9;
  localparam logic [3:0] S_DD_R  = 4'd10;
  localparam logic [3:0] S_DD_C  = 4'd11;

  logic [3:0]    state;
  logic [AW-1:0] front;
  logic [5:0]    count;
  logic [5:0]    pi, pj;
  rlsd_pkg::word_t va, vb;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  rlsd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [5:0] p);
    logic [6:0] s;
    s = 7'(f) + 7'(p);
    if (s >= 7'(DEPTH)) s = s - 7'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign in_stall = (state != S_IDLE);
  logic take;
  assign take = in_valid && !in_stall;
  logic out_go;
  assign out_go = out_valid && !out_stall;
  assign entry_count = count;

  always_comb begin
    we = 1'b0;
    waddr = slot(front, pi);
    wdata = value;
    raddr = slot(front, pi);
    if (state == S_IDLE && take) begin
      if (mode == rlsd_pkg::MODE_INS_FRONT && count < DEPTH_C) begin
        we = 1'b1;
        waddr = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
      end else if (mode == rlsd_pkg::MODE_INS_BACK && count < DEPTH_C) begin
        we = 1'b1;
        waddr = slot(front, count);
      end
    end
    if (state == S_SO_B || state == S_SO_C) raddr = slot(front, pj);
    if (state == S_SO_C && $signed(rdata) < va) begin
      we = 1'b1; waddr = slot(front, pi); wdata = rdata;
    end
    if (state == S_SO_W) begin
      we = 1'b1; waddr = slot(front, pj); wdata = va;
    end
    if (state == S_DD_W || state == S_DD_R) raddr = slot(front, pj);
    if (state == S_DD_C && rdata != va) begin
      we = 1'b1; waddr = slot(front, pi + 6'd1); wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_go) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (take) begin
          entry_value <= '0;
          last <= 1'b1;
          pi <= '0;
          if (mode == rlsd_pkg::MODE_INS_FRONT || mode == rlsd_pkg::MODE_INS_BACK) begin
            state <= S_OUT;
            out_valid <= 1'b1;
            if (count >= DEPTH_C) status <= rlsd_pkg::ST_FULL;
            else begin
              status <= rlsd_pkg::ST_OK;
              count <= count + 6'd1;
              if (mode == rlsd_pkg::MODE_INS_FRONT)
                front <= (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
            end
          end else if (mode != rlsd_pkg::MODE_NONE && count == '0) begin
            status <= rlsd_pkg::ST_EMPTY;
            state <= S_OUT;
            out_valid <= 1'b1;
          end else if (mode == rlsd_pkg::MODE_DEL_FRONT
                       || mode == rlsd_pkg::MODE_DEL_BACK) begin
            status <= rlsd_pkg::ST_OK;
            state <= S_OUT;
            out_valid <= 1'b1;
            count <= count - 6'd1;
            if (mode == rlsd_pkg::MODE_DEL_FRONT) front <= slot(front, 6'd1);
          end else if (mode == rlsd_pkg::MODE_READ) begin
            status <= rlsd_pkg::ST_OK;
            state <= S_RD_A;
          end else if (mode == rlsd_pkg::MODE_SORT) begin
            status <= rlsd_pkg::ST_OK;
            state <= (count < 6'd2) ? S_OUT : S_SO_A;
            out_valid <= (count < 6'd2);
            pj <= 6'd1;
          end else if (mode == rlsd_pkg::MODE_DEDUP) begin
            status <= rlsd_pkg::ST_OK;
            state <= S_DD_W; pj <= '0;
          end else begin
            status <= rlsd_pkg::ST_OK;
            state <= S_OUT;
            out_valid <= 1'b1;
          end
        end
        S_OUT: if (out_go) state <= S_IDLE;
        S_RD_A: state <= S_RD_W;
        S_RD_W: begin
          entry_value <= rdata;
          last <= (pi + 6'd1 == count);
          out_valid <= 1'b1;
          state <= S_RD_O;
        end
        S_RD_O: if (out_go) begin
          if (last) state <= S_IDLE;
          else begin pi <= pi + 6'd1; state <= S_RD_A; end
        end
        S_SO_A: state <= S_SO_B;
        S_SO_B: begin va <= rdata; state <= S_SO_C; end
        S_SO_C: begin
          if ($signed(rdata) < va) begin
            state <= S_SO_W;
          end else if (pj + 6'd1 < count) begin
            pj <= pj + 6'd1; state <= S_SO_A;
          end else if (pi + 6'd2 < count) begin
            pi <= pi + 6'd1; pj <= pi + 6'd2; state <= S_SO_A;
          end else begin
            out_valid <= 1'b1; state <= S_OUT;
          end
        end
        S_SO_W: begin
          if (pj + 6'd1 < count) begin
            pj <= pj + 6'd1; state <= S_SO_A;
          end else if (pi + 6'd2 < count) begin
            pi <= pi + 6'd1; pj <= pi + 6'd2; state <= S_SO_A;
          end else begin
            out_valid <= 1'b1; state <= S_OUT;
          end
        end
        S_DD_W: begin pj <= 6'd1; state <= S_DD_R; end
        S_DD_R: begin
          if (pj == 6'd1) va <= rdata;
          if (pj >= count) begin
            count <= pi + 6'd1; out_valid <= 1'b1; state <= S_OUT;
          end else state <= S_DD_C;
        end
        S_DD_C: begin
          if (rdata != va) begin pi <= pi + 6'd1; va <= rdata; end
          pj <= pj + 6'd1;
          state <= S_DD_R;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("count above depth");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !take)
    else $error("command taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (out_go && last) |=> state == S_IDLE)
    else $error("no return to idle after final result");

endmodule

/* hdl/rlsd_ram.sv */
// ----------------------------------------------------------------------------
// rlsd_ram
// Generic simple dual-port RAM, one write and one read per cycle, registered read.
// ----------------------------------------------------------------------------
module rlsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
